[sv/cws_pkg.sv]
// Shared constants, types and helpers for the channel window statistics core.
// No dependencies; cws_front, cws_div, cws_back and the top level import this package.
`default_nettype none

package cws_pkg;

   localparam int CHANNELS    = 16;
   localparam int WINDOW      = 10;
   localparam int SAMPLE_BITS = 16;

   localparam int CH_FIELD_W = 4;
   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int COUNT_W    = $clog2(WINDOW + 1);
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW);

   localparam int STORE_DEPTH  = CHANNELS * WINDOW;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int REQ_BITS    = CH_FIELD_W + SAMPLE_BITS;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 3 * SAMPLE_BITS + COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // One classified sample waiting for the back end
   typedef struct packed {
      logic [CH_IDX_W-1:0]           idx;
      logic signed [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIV,
      ST_DONE
   } state_type;

   // Fold the channel field onto the implemented channels (small table)
   function automatic logic [CH_IDX_W-1:0] chan_index(input logic [CH_FIELD_W-1:0] ch);
      logic [CH_IDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2 ** CH_FIELD_W; i++) begin
         if (ch == CH_FIELD_W'(i)) begin
            r = CH_IDX_W'(i % CHANNELS);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/cws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cws_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 160,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sv/cws_front.sv]
// Front end: accepts sample transfers, folds the channel index, queues items.
// Depends on cws_pkg.
`default_nettype none

module cws_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [cws_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                  q_valid,
   output cws_pkg::item_type                     q_item,
   input  wire logic                             q_pop
);
   import cws_pkg::*;

   item_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push;
   item_type            new_item;

   assign req_tready = (cnt_ff < QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_item     = q_ff[rptr_ff];

   always_comb begin
      new_item.idx    = chan_index(req_tdata[CH_FIELD_W-1:0]);
      new_item.sample = req_tdata[REQ_BITS-1:CH_FIELD_W];
   end

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (q_pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[sv/cws_div.sv]
// Restoring divider: one quotient bit per cycle, unsigned window sum by count.
// Depends on cws_pkg.
`default_nettype none

module cws_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cws_pkg::div_req_type div_req,
   output cws_pkg::div_rsp_type div_rsp
);
   import cws_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [COUNT_W-1:0]   divisor_ff;
   logic [COUNT_W:0]     trial;
   logic [COUNT_W:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = '0;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (div_req.start) begin
         divisor_ff <= div_req.divisor;
      end
   end

   always_comb begin
      div_rsp.done     = done_ff;
      div_rsp.quotient = quo_ff;
   end

endmodule

`default_nettype wire

[sv/cws_back.sv]
// Back end: per-channel state, window memory, divider sequencing, result register.
// Depends on cws_pkg, cws_ram and cws_div.
`default_nettype none

module cws_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_valid,
   input  wire cws_pkg::item_type                q_item,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [cws_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import cws_pkg::*;

   state_type state_ff, state_in;

   // Per-channel state
   logic [CHANNELS-1:0]           seen_ff;
   logic signed [SAMPLE_BITS-1:0] low_arr_ff  [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] high_arr_ff [CHANNELS];
   logic signed [SUM_W-1:0]       sum_arr_ff  [CHANNELS];
   logic [COUNT_W-1:0]            fill_arr_ff [CHANNELS];
   logic [SLOT_W-1:0]             old_arr_ff  [CHANNELS];

   // Working copy of the item in flight
   logic [CH_IDX_W-1:0]           idx_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [SLOT_W-1:0]             slot_ff;
   logic [STORE_ADDR_W-1:0]       addr_ff;
   logic                          seen_was_ff;
   logic                          full_ff;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] low_ff, low_in;
   logic signed [SAMPLE_BITS-1:0] high_ff, high_in;
   logic [COUNT_W-1:0]            fill_ff, fill_in;
   logic [SLOT_W-1:0]             old_in;
   logic                          neg_ff;

   // Lookup for the item at the queue head
   logic                          head_seen;
   logic [COUNT_W-1:0]            head_fill;
   logic                          head_full;
   logic [SLOT_W-1:0]             head_slot;
   logic [STORE_ADDR_W-1:0]       head_addr;

   logic                          do_update;
   logic                          do_start;
   logic                          do_load;
   logic                          out_free;

   logic [SAMPLE_BITS-1:0]        old_raw;
   logic signed [SAMPLE_BITS-1:0] old_val;

   div_req_type                   div_req;
   div_rsp_type                   div_rsp;
   logic [SUM_W-1:0]              avg_wide;
   logic [RSP_TDATA_W-1:0]        rsp_in;
   logic                          rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]        rsp_data_ff;

   cws_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_update),
      .wr_addr (addr_ff),
      .wr_data (x_ff),
      .rd_en   (q_pop),
      .rd_addr (head_addr),
      .rd_data (old_raw)
   );

   cws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign old_val = old_raw;

   // Slot of the head item: first slot, next free slot, or oldest slot
   always_comb begin
      head_seen = seen_ff[q_item.idx];
      head_fill = fill_arr_ff[q_item.idx];
      head_full = head_seen && (head_fill == COUNT_W'(WINDOW));
      if (!head_seen) begin
         head_slot = '0;
      end else if (head_full) begin
         head_slot = old_arr_ff[q_item.idx];
      end else begin
         head_slot = SLOT_W'(head_fill);
      end
      head_addr = STORE_ADDR_W'(q_item.idx) * STORE_ADDR_W'(WINDOW)
                + STORE_ADDR_W'(head_slot);
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (q_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_START;
         ST_START:  state_in = ST_DIV;
         ST_DIV:    if (div_rsp.done) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State decodes
   always_comb begin
      q_pop     = 1'b0;
      do_update = 1'b0;
      do_start  = 1'b0;
      do_load   = 1'b0;
      case (state_ff)
         ST_IDLE:   q_pop     = q_valid;
         ST_UPDATE: do_update = 1'b1;
         ST_START:  do_start  = 1'b1;
         ST_DONE:   do_load   = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // New statistics for the item in flight
   always_comb begin
      if (!seen_was_ff) begin
         sum_in  = SUM_W'(x_ff);
         low_in  = x_ff;
         high_in = x_ff;
         fill_in = COUNT_W'(1);
         old_in  = '0;
      end else begin
         low_in  = (x_ff < low_arr_ff[idx_ff])  ? x_ff : low_arr_ff[idx_ff];
         high_in = (x_ff > high_arr_ff[idx_ff]) ? x_ff : high_arr_ff[idx_ff];
         if (full_ff) begin
            sum_in  = sum_arr_ff[idx_ff] + SUM_W'(x_ff) - SUM_W'(old_val);
            fill_in = fill_arr_ff[idx_ff];
            old_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         end else begin
            sum_in  = sum_arr_ff[idx_ff] + SUM_W'(x_ff);
            fill_in = fill_arr_ff[idx_ff] + 1'b1;
            old_in  = old_arr_ff[idx_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (do_update) begin
         seen_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         idx_ff      <= q_item.idx;
         x_ff        <= q_item.sample;
         slot_ff     <= head_slot;
         addr_ff     <= head_addr;
         seen_was_ff <= head_seen;
         full_ff     <= head_full;
      end
      if (do_update) begin
         low_arr_ff[idx_ff]  <= low_in;
         high_arr_ff[idx_ff] <= high_in;
         sum_arr_ff[idx_ff]  <= sum_in;
         fill_arr_ff[idx_ff] <= fill_in;
         old_arr_ff[idx_ff]  <= old_in;
         sum_ff  <= sum_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         fill_ff <= fill_in;
      end
      if (do_start) begin
         neg_ff <= sum_ff[SUM_W-1];
      end
   end

   // Divide the magnitude, restore the sign afterward: truncates toward zero
   always_comb begin
      div_req.start    = do_start;
      div_req.dividend = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
      div_req.divisor  = fill_ff;
   end

   assign avg_wide = neg_ff ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

   always_comb begin
      rsp_in = '0;
      rsp_in[RSP_BITS-1:0] = {fill_ff, avg_wide[SAMPLE_BITS-1:0], high_ff, low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[sv/channel_window_statistics_core.sv]
// Per-channel moving average with all-time minimum and maximum.
// Each item passes pop, update, start, the bit-serial divider (20 quotient bits,
// one per cycle, then a completion flag) and the result load; the back end pops
// a new item only after loading the last result, and waits while the output stalls.
// Reset is synchronous, active high: clears the queue, sequencer, seen flags
// and result valid; the window memory and per-channel values are not cleared.
`default_nettype none

module channel_window_statistics_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Sample input
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // req_tdata, lowest bit up: channel[3:0], sample[19:4], zero pad
   input  wire logic [cws_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Statistics output
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata, lowest bit up: minimum[15:0], maximum[31:16], average[47:32],
   // held_count[51:48], zero pad
   output logic [cws_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import cws_pkg::*;

   // Queue between front and back: classified items wait here so the input side
   // can take up to two transfers while the back end works or the output stalls
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   cws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back end: one item at a time through lookup, update, divide, result
   cws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Result fields, split out for the checks below
   logic signed [SAMPLE_BITS-1:0] rsp_min;
   logic signed [SAMPLE_BITS-1:0] rsp_max;
   logic signed [SAMPLE_BITS-1:0] rsp_avg;
   logic [COUNT_W-1:0]            rsp_held;

   assign rsp_min  = rsp_tdata[SAMPLE_BITS-1:0];
   assign rsp_max  = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rsp_avg  = rsp_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
   assign rsp_held = rsp_tdata[RSP_BITS-1:3*SAMPLE_BITS];

   // Minimum never exceeds maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_min <= rsp_max)
      else $error("minimum above maximum");

   // Average of the window lies inside the all-time range
   a_avg_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_avg >= rsp_min) && (rsp_avg <= rsp_max))
      else $error("average outside minimum and maximum");

   // Window holds between one and WINDOW samples
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_held != '0) && (rsp_held <= COUNT_W'(WINDOW)))
      else $error("held count out of range");

endmodule

`default_nettype wire
